### design/vcsu_pkg.sv
// Shared types, codes and helpers for the video command and scanout unit.
// No dependencies.
package vcsu_pkg;

   typedef enum logic [1:0] {
      FUNC_CMD    = 2'd0,
      FUNC_PIXEL  = 2'd1,
      FUNC_SCAN   = 2'd2,
      FUNC_STATUS = 2'd3
   } func_type;

   localparam logic [2:0] CMD_SETVPAGE = 3'd0;
   localparam logic [2:0] CMD_SETPAL   = 3'd1;
   localparam logic [2:0] CMD_VMODE    = 3'd2;
   localparam logic [2:0] CMD_REGSEL   = 3'd3;
   localparam logic [2:0] CMD_REGSET   = 3'd4;
   localparam logic [2:0] CMD_REGCLR   = 3'd5;

   localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
   localparam logic [9:0]  WIDE_WIDTH   = 10'd640;
   localparam logic [9:0]  NARROW_WIDTH = 10'd320;

   localparam int PAL_IDX_W  = 8;
   localparam int PAL_DATA_W = 24;

   // palette write request from the command decoder
   typedef struct packed {
      logic                  we;
      logic [PAL_IDX_W-1:0]  idx;
      logic [PAL_DATA_W-1:0] rgb;
   } pal_wr_type;

   // control state and per-transaction results from the decoder
   typedef struct packed {
      logic        video_on;
      logic        rgb12;
      logic [31:0] row_address;
      logic        line_active;
      logic        pixel_doubled;
      logic        line_irq;
      logic        status_bit;
   } ctrl_out_type;

   // 12-bit color: 11..8 R, 7..4 B, 3..0 G -> 24-bit RGB, nibbles in the upper halves
   function automatic logic [PAL_DATA_W-1:0] expand12(input logic [11:0] c);
      return {c[11:8], 4'h0, c[3:0], 4'h0, c[7:4], 4'h0};
   endfunction

endpackage

### design/video_command_and_scanout_unit.sv
// Top level of the video command and scanout unit: handshake, palette, result pipeline.
// Depends on vcsu_pkg, vcsu_ram, vcsu_ctrl.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | func, word, source_pixel, line_number
//   rsp     | out       | rsp_valid/rsp_stall | color, row_address, line_active,
//           |           |                     | pixel_doubled, line_irq, status_bit
//
// One transaction per cycle while req_stall is low; each result passes through the middle
// stage (alongside the palette RAM's registered read) and then the output register.
// Reset is synchronous; the palette's valid bits clear at once, so no clearing pass.
// A stalled output holds; the middle stage keeps taking transactions until it also
// fills, then req_stall rises.
module video_command_and_scanout_unit #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int ACTIVE_LINES    = 480,
   parameter int VSYNC_LINE      = 490
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_word,
   input  logic [15:0] req_source_pixel,
   input  logic [9:0]  req_line_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_color,
   output logic [31:0] rsp_row_address,
   output logic        rsp_line_active,
   output logic        rsp_pixel_doubled,
   output logic        rsp_line_irq,
   output logic        rsp_status_bit
);
   import vcsu_pkg::*;

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
   localparam logic [PAL_IDX_W:0] PAL_LIMIT = (PAL_IDX_W + 1)'(PALETTE_ENTRIES);

   func_type     func;
   ctrl_out_type ctrl;
   pal_wr_type   pal_wr;
   logic         accept;
   logic         advance;

   logic [PALETTE_ENTRIES-1:0] pal_valid_ff, pal_valid_in;
   logic [PAL_IDX_W-1:0]  rd_idx;
   logic                  rd_in_range;
   logic                  wr_in_range;
   logic                  pal_hit;
   logic [PAL_DATA_W-1:0] pal_rdata;

   // middle stage
   logic        a_valid_ff, a_valid_in;
   logic [31:0] a_color_ff;
   logic        a_use_pal_ff;
   logic        a_hit_ff;
   logic [31:0] a_row_ff;
   logic        a_active_ff;
   logic        a_doubled_ff;
   logic        a_irq_ff;
   logic        a_status_ff;

   // output stage
   logic        b_valid_ff, b_valid_in;
   logic [31:0] b_color_ff, b_color_in;
   logic [31:0] b_row_ff;
   logic        b_active_ff;
   logic        b_doubled_ff;
   logic        b_irq_ff;
   logic        b_status_ff;

   assign func      = func_type'(req_func);
   assign advance   = ~b_valid_ff | ~rsp_stall;
   assign req_stall = a_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   vcsu_ctrl #(
      .ACTIVE_LINES (ACTIVE_LINES),
      .VSYNC_LINE   (VSYNC_LINE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (func),
      .word        (req_word),
      .line_number (req_line_number),
      .ctrl        (ctrl),
      .pal_wr      (pal_wr)
   );

   assign rd_idx      = req_source_pixel[7:0];
   assign rd_in_range = {1'b0, rd_idx} < PAL_LIMIT;
   assign wr_in_range = {1'b0, pal_wr.idx} < PAL_LIMIT;
   assign pal_hit     = rd_in_range ? pal_valid_ff[rd_idx[PAL_AW-1:0]] : 1'b0;

   vcsu_ram #(
      .WIDTH (PAL_DATA_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock (clock),
      .we    (pal_wr.we & wr_in_range),
      .waddr (pal_wr.idx[PAL_AW-1:0]),
      .wdata (pal_wr.rgb),
      .re    (accept),
      .raddr (rd_idx[PAL_AW-1:0]),
      .rdata (pal_rdata)
   );

   always_comb begin
      pal_valid_in = pal_valid_ff;
      if (pal_wr.we && wr_in_range) begin
         pal_valid_in[pal_wr.idx[PAL_AW-1:0]] = 1'b1;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      if (advance) begin
         b_valid_in = a_valid_ff;
      end
      if (a_use_pal_ff) begin
         b_color_in = ALPHA_OPAQUE | {8'd0, (a_hit_ff ? pal_rdata : '0)};
      end else begin
         b_color_in = a_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         pal_valid_ff <= pal_valid_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_use_pal_ff <= (func == FUNC_PIXEL) && ctrl.video_on && !ctrl.rgb12;
         a_hit_ff     <= pal_hit;
         if ((func == FUNC_PIXEL) && ctrl.video_on && ctrl.rgb12) begin
            a_color_ff <= ALPHA_OPAQUE | {8'd0, expand12(req_source_pixel[11:0])};
         end else begin
            a_color_ff <= 32'd0;
         end
         a_row_ff     <= ctrl.row_address;
         a_active_ff  <= ctrl.line_active;
         a_doubled_ff <= ctrl.pixel_doubled;
         a_irq_ff     <= ctrl.line_irq;
         a_status_ff  <= ctrl.status_bit;
      end
      if (advance && a_valid_ff) begin
         b_color_ff   <= b_color_in;
         b_row_ff     <= a_row_ff;
         b_active_ff  <= a_active_ff;
         b_doubled_ff <= a_doubled_ff;
         b_irq_ff     <= a_irq_ff;
         b_status_ff  <= a_status_ff;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_color         = b_color_ff;
   assign rsp_row_address   = b_row_ff;
   assign rsp_line_active   = b_active_ff;
   assign rsp_pixel_doubled = b_doubled_ff;
   assign rsp_line_irq      = b_irq_ff;
   assign rsp_status_bit    = b_status_ff;

endmodule

### design/vcsu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vcsu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/vcsu_ctrl.sv
// Command decoder, mode/register state and scanline logic.
// Depends on vcsu_pkg.
module vcsu_ctrl #(
   parameter int ACTIVE_LINES = 480,
   parameter int VSYNC_LINE   = 490
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  vcsu_pkg::func_type    func,
   input  logic [31:0]           word,
   input  logic [9:0]            line_number,
   output vcsu_pkg::ctrl_out_type ctrl,
   output vcsu_pkg::pal_wr_type   pal_wr
);
   import vcsu_pkg::*;

   localparam logic [9:0] ACTIVE_LIM = 10'(ACTIVE_LINES);
   localparam logic [9:0] VSYNC_LIM  = 10'(VSYNC_LINE);

   logic        awaiting_ff, awaiting_in;
   logic [2:0]  pending_ff, pending_in;
   logic [31:0] scanout_ff, scanout_in;
   logic        video_en_ff, video_en_in;
   logic        wide_ff, wide_in;
   logic        rgb12_ff, rgb12_in;
   logic        select_b_ff, select_b_in;
   logic [31:0] reg_a_ff, reg_a_in;
   logic [31:0] reg_b_ff, reg_b_in;
   logic        irq_ff, irq_in;
   logic        parity_ff, parity_in;

   logic        video_on;
   logic        line_ok;
   logic [9:0]  y;
   logic [9:0]  w;
   logic [19:0] offset;
   logic [31:0] row;

   assign video_on = (scanout_ff != 32'd0) && video_en_ff;
   assign line_ok  = video_on && (line_number < ACTIVE_LIM);

   // row offset: width * y, doubled for 16-bit pixels
   assign y      = wide_ff ? line_number : {1'b0, line_number[9:1]};
   assign w      = wide_ff ? WIDE_WIDTH : NARROW_WIDTH;
   assign offset = y * w;
   assign row    = scanout_ff + (rgb12_ff ? {11'd0, offset, 1'b0} : {12'd0, offset});

   always_comb begin
      awaiting_in = awaiting_ff;
      pending_in  = pending_ff;
      scanout_in  = scanout_ff;
      video_en_in = video_en_ff;
      wide_in     = wide_ff;
      rgb12_in    = rgb12_ff;
      select_b_in = select_b_ff;
      reg_a_in    = reg_a_ff;
      reg_b_in    = reg_b_ff;
      irq_in      = irq_ff;
      parity_in   = parity_ff;
      pal_wr.we   = 1'b0;
      pal_wr.idx  = word[31:24];
      pal_wr.rgb  = expand12(word[11:0]);
      if (accept) begin
         unique case (func)
            FUNC_CMD: begin
               if (awaiting_ff) begin
                  awaiting_in = 1'b0;
                  unique case (pending_ff)
                     CMD_SETVPAGE: scanout_in = word;
                     CMD_SETPAL:   pal_wr.we = 1'b1;
                     CMD_VMODE: begin
                        video_en_in = word[0];
                        wide_in     = word[1];
                        rgb12_in    = word[2];
                     end
                     CMD_REGSEL:   select_b_in = word[0];
                     CMD_REGSET: begin
                        if (select_b_ff) begin
                           reg_b_in = word;
                        end else begin
                           reg_a_in = reg_a_ff | word;
                        end
                     end
                     CMD_REGCLR: begin
                        if (select_b_ff) begin
                           reg_b_in = 32'd0;
                        end else begin
                           reg_a_in = reg_a_ff & ~word;
                        end
                     end
                     default: ;
                  endcase
               end else if (word <= 32'(CMD_REGCLR)) begin
                  pending_in  = word[2:0];
                  awaiting_in = 1'b1;
               end
            end
            FUNC_SCAN: begin
               if (line_ok) begin
                  irq_in = ({22'd0, line_number} >= reg_b_ff) && reg_a_ff[0];
               end
               if (line_number == VSYNC_LIM) begin
                  parity_in = ~parity_ff;
               end
            end
            FUNC_PIXEL, FUNC_STATUS: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         pending_ff  <= 3'd0;
         scanout_ff  <= 32'd0;
         video_en_ff <= 1'b0;
         wide_ff     <= 1'b0;
         rgb12_ff    <= 1'b0;
         select_b_ff <= 1'b0;
         reg_a_ff    <= 32'd0;
         reg_b_ff    <= 32'd0;
         irq_ff      <= 1'b0;
         parity_ff   <= 1'b0;
      end else begin
         awaiting_ff <= awaiting_in;
         pending_ff  <= pending_in;
         scanout_ff  <= scanout_in;
         video_en_ff <= video_en_in;
         wide_ff     <= wide_in;
         rgb12_ff    <= rgb12_in;
         select_b_ff <= select_b_in;
         reg_a_ff    <= reg_a_in;
         reg_b_ff    <= reg_b_in;
         irq_ff      <= irq_in;
         parity_ff   <= parity_in;
      end
   end

   always_comb begin
      ctrl.video_on      = video_on;
      ctrl.rgb12         = rgb12_ff;
      ctrl.line_active   = (func == FUNC_SCAN) && line_ok;
      ctrl.row_address   = ctrl.line_active ? row : 32'd0;
      ctrl.pixel_doubled = ~wide_in;
      ctrl.line_irq      = irq_in;
      ctrl.status_bit    = parity_in;
   end

endmodule
